// File: rtl/core/wsg_pkg.sv
// ----------------------------------------------------------------------------
// Waypoint steering guidance package
// Beat types, fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package wsg_pkg;

    // Default sizing
    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int CORDIC_ITER_DEF  = 16;
    localparam int ATAN_TAB_LEN     = 24;

    // CORDIC datapath widths: vector magnitude stays below 2^26, angle below 2^27
    localparam int XY_W = 27;
    localparam int Z_W  = 28;

    // Opcodes of the input beat
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // Status codes of the result beat
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // Angle constants
    localparam logic signed [18:0]  PI_Q12     = 19'sd12868;
    localparam logic signed [18:0]  TWO_PI_Q12 = 19'sd25736;
    localparam logic signed [Z_W-1:0] PI_Q24   = 28'sd52707179;
    localparam logic signed [Z_W-1:0] ROUND_Q12 = 28'sd2048;

    // Reset value of the reach radius (0.2 m in Q4.12)
    localparam logic [15:0] TOL_RESET = 16'd819;

    typedef struct packed {
        logic               opcode;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [15:0] heading;
    } in_beat_t;

    typedef struct packed {
        logic signed [15:0] steer_angle;
        logic               throttle_on;
        logic               advanced;
        logic               all_done;
        logic [1:0]         status_code;
    } out_beat_t;

    // Data handed from one CORDIC cell to the next
    typedef struct packed {
        logic                  valid;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_beat_t;

    // atan(2^-i) in Q.24 radians
    function automatic logic signed [Z_W-1:0] atan_q24(input int idx);
        logic signed [Z_W-1:0] a;
        begin
            case (idx)
                0:       a = 28'sd13176795;
                1:       a = 28'sd7778716;
                2:       a = 28'sd4110060;
                3:       a = 28'sd2086331;
                4:       a = 28'sd1047214;
                5:       a = 28'sd524117;
                6:       a = 28'sd262123;
                7:       a = 28'sd131069;
                8:       a = 28'sd65536;
                9:       a = 28'sd32768;
                10:      a = 28'sd16384;
                11:      a = 28'sd8192;
                12:      a = 28'sd4096;
                13:      a = 28'sd2048;
                14:      a = 28'sd1024;
                15:      a = 28'sd512;
                16:      a = 28'sd256;
                17:      a = 28'sd128;
                18:      a = 28'sd64;
                19:      a = 28'sd32;
                20:      a = 28'sd16;
                21:      a = 28'sd8;
                22:      a = 28'sd4;
                23:      a = 28'sd2;
                default: a = '0;
            endcase
            return a;
        end
    endfunction

endpackage

// File: rtl/core/wsg_cordic_cell.sv
// ----------------------------------------------------------------------------
// Waypoint steering CORDIC cell
// One vectoring micro-rotation with a fixed shift, registered toward the
// next cell of the chain.
// ----------------------------------------------------------------------------
module wsg_cordic_cell #(
    parameter int SHIFT = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  wsg_pkg::cordic_beat_t beat_in,
    output wsg_pkg::cordic_beat_t beat_out
);

    localparam logic signed [wsg_pkg::Z_W-1:0] ANGLE = wsg_pkg::atan_q24(SHIFT);

    logic                               valid_reg;
    logic signed [wsg_pkg::XY_W-1:0]    x_reg, x_next;
    logic signed [wsg_pkg::XY_W-1:0]    y_reg, y_next;
    logic signed [wsg_pkg::Z_W-1:0]     z_reg, z_next;
    logic signed [wsg_pkg::XY_W-1:0]    x_sh, y_sh;

    // Rotate toward y = 0
    always_comb
    begin
        x_sh = beat_in.x >>> SHIFT;
        y_sh = beat_in.y >>> SHIFT;
        if (!beat_in.y[wsg_pkg::XY_W-1])
        begin
            x_next = beat_in.x + y_sh;
            y_next = beat_in.y - x_sh;
            z_next = beat_in.z + ANGLE;
        end
        else
        begin
            x_next = beat_in.x - y_sh;
            y_next = beat_in.y + x_sh;
            z_next = beat_in.z - ANGLE;
        end
    end

    // Valid travels with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= beat_in.valid;
    end

    // Payload
    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign beat_out.valid = valid_reg;
    assign beat_out.x     = x_reg;
    assign beat_out.y     = y_reg;
    assign beat_out.z     = z_reg;

endmodule

// File: rtl/core/wsg_cordic_chain.sv
// ----------------------------------------------------------------------------
// Waypoint steering CORDIC chain
// Row of CORDIC cells, cell i applies the 2^-i micro-rotation.
// ----------------------------------------------------------------------------
module wsg_cordic_chain #(
    parameter int CORDIC_ITERATIONS = wsg_pkg::CORDIC_ITER_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  wsg_pkg::cordic_beat_t chain_in,
    output wsg_pkg::cordic_beat_t chain_out
);

    wsg_pkg::cordic_beat_t link [CORDIC_ITERATIONS+1];

    assign link[0] = chain_in;

    for (genvar i = 0; i < CORDIC_ITERATIONS; i++)
    begin : g_cell
        wsg_cordic_cell #(
            .SHIFT (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .beat_in  (link[i]),
            .beat_out (link[i+1])
        );
    end

    assign chain_out = link[CORDIC_ITERATIONS];

endmodule

// File: rtl/core/waypoint_steering_guidance_top.sv
// ----------------------------------------------------------------------------
// Waypoint steering guidance top level
// Accept to result valid: a load or a step on an empty queue runs decode, emit;
// a step dropping the last waypoint adds diff, mul, cmp; any other step adds
// launch, CORDIC chain and final, plus rdwait and diff if the head is dropped.
// One item at a time; the next beat is taken the cycle after the result is
// registered, even while it is stalled. Reset empties the queue, radius 0.2 m.
// ----------------------------------------------------------------------------
module waypoint_steering_guidance_top #(
    parameter int QUEUE_DEPTH       = wsg_pkg::QUEUE_DEPTH_DEF,
    parameter int CORDIC_ITERATIONS = wsg_pkg::CORDIC_ITER_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  wsg_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output wsg_pkg::out_beat_t out_data,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    // Sequencer states
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECODE = 4'd1;
    localparam logic [3:0] ST_RDWAIT = 4'd2;
    localparam logic [3:0] ST_DIFF   = 4'd3;
    localparam logic [3:0] ST_MUL    = 4'd4;
    localparam logic [3:0] ST_CMP    = 4'd5;
    localparam logic [3:0] ST_LAUNCH = 4'd6;
    localparam logic [3:0] ST_RUN    = 4'd7;
    localparam logic [3:0] ST_FINAL  = 4'd8;
    localparam logic [3:0] ST_EMIT   = 4'd9;

    // Control registers
    logic [3:0]        state_reg, state_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              adv_reg, adv_next;
    logic [15:0]       tol_reg;
    logic              out_valid_reg, out_valid_next;

    // Payload registers
    wsg_pkg::in_beat_t  item_reg;
    wsg_pkg::out_beat_t res_reg, res_next;
    wsg_pkg::out_beat_t out_data_reg;
    logic [47:0]               rd_q_reg;
    logic signed [24:0]        dx_reg, dy_reg;
    logic [47:0]               sqx_reg, sqy_reg;
    logic [31:0]               tol2_reg;
    logic signed [16:0]        bearing_reg, bearing_next;

    // Waypoint store
    logic [47:0] mem [QUEUE_DEPTH];

    logic                  in_acc;
    logic                  out_free;
    logic                  do_write;
    logic signed [49:0]    prod_x, prod_y;
    logic [48:0]           d2;
    logic signed [24:0]    dx_next, dy_next;
    wsg_pkg::cordic_beat_t chain_in, chain_out;
    logic signed [wsg_pkg::Z_W-1:0] z_round;
    logic signed [18:0]    t_ext, h_ext, steer_raw;
    logic [PTR_W-1:0]      rd_ptr_inc, wr_ptr_inc;

    assign in_acc   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign do_write = (state_reg == ST_DECODE) && (item_reg.opcode == wsg_pkg::OP_LOAD)
                      && (count_reg != CNT_FULL);

    assign rd_ptr_inc = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
    assign wr_ptr_inc = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;

    // Store write and registered head read
    always_ff @(posedge clk)
    begin
        if (do_write)
            mem[wr_ptr_reg] <= {item_reg.pos_x, item_reg.pos_y};
        rd_q_reg <= mem[rd_ptr_reg];
    end

    // Offsets to the head waypoint
    assign dx_next = $signed({rd_q_reg[47], rd_q_reg[47:24]})
                     - $signed({item_reg.pos_x[23], item_reg.pos_x});
    assign dy_next = $signed({rd_q_reg[23], rd_q_reg[23:0]})
                     - $signed({item_reg.pos_y[23], item_reg.pos_y});

    // Squared distance terms
    assign prod_x = dx_reg * dx_reg;
    assign prod_y = dy_reg * dy_reg;
    assign d2     = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    // CORDIC start vector, folded into the right half plane
    always_comb
    begin
        chain_in.valid = (state_reg == ST_LAUNCH);
        if (dy_reg[24])
        begin
            chain_in.x = -wsg_pkg::XY_W'(dy_reg);
            chain_in.y = -wsg_pkg::XY_W'(dx_reg);
            chain_in.z = wsg_pkg::PI_Q24;
        end
        else
        begin
            chain_in.x = wsg_pkg::XY_W'(dy_reg);
            chain_in.y = wsg_pkg::XY_W'(dx_reg);
            chain_in.z = '0;
        end
    end

    wsg_cordic_chain #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .chain_in  (chain_in),
        .chain_out (chain_out)
    );

    // Bearing in [0, 2pi), Q3.12
    always_comb
    begin
        z_round = chain_out.z + wsg_pkg::ROUND_Q12;
        if (dx_reg == '0)
            bearing_next = dy_reg[24] ? 17'(wsg_pkg::PI_Q12) : '0;
        else if (!dy_reg[24] && dx_reg[24])
            bearing_next = $signed({z_round[27], z_round[27:12]}) + 17'(wsg_pkg::TWO_PI_Q12);
        else
            bearing_next = $signed({z_round[27], z_round[27:12]});
    end

    // Steering: bearing minus heading, wrapped once, saturated
    always_comb
    begin
        t_ext = 19'(bearing_reg);
        h_ext = 19'(item_reg.heading);
        steer_raw = t_ext - h_ext;
        if (h_ext > t_ext + wsg_pkg::PI_Q12)
            steer_raw = steer_raw + wsg_pkg::TWO_PI_Q12;
        else if (h_ext < t_ext - wsg_pkg::PI_Q12)
            steer_raw = steer_raw - wsg_pkg::TWO_PI_Q12;
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        count_next     = count_reg;
        adv_next       = adv_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                res_next = '0;
                adv_next = 1'b0;
                if (item_reg.opcode == wsg_pkg::OP_LOAD)
                begin
                    if (count_reg == CNT_FULL)
                        res_next.status_code = wsg_pkg::STATUS_FULL;
                    else
                    begin
                        wr_ptr_next = wr_ptr_inc;
                        count_next  = count_reg + 1'b1;
                    end
                    state_next = ST_EMIT;
                end
                else if (count_reg == '0)
                begin
                    res_next.all_done    = 1'b1;
                    res_next.status_code = wsg_pkg::STATUS_EMPTY;
                    state_next = ST_EMIT;
                end
                else
                    state_next = ST_DIFF;
            end
            ST_RDWAIT:
                state_next = ST_DIFF;
            ST_DIFF:
                state_next = adv_reg ? ST_LAUNCH : ST_MUL;
            ST_MUL:
                state_next = ST_CMP;
            ST_CMP:
            begin
                if (d2 <= {17'd0, tol2_reg})
                begin
                    rd_ptr_next = rd_ptr_inc;
                    count_next  = count_reg - 1'b1;
                    adv_next    = 1'b1;
                    if (count_reg == CNT_ONE)
                    begin
                        res_next.advanced = 1'b1;
                        res_next.all_done = 1'b1;
                        state_next = ST_EMIT;
                    end
                    else
                        state_next = ST_RDWAIT;
                end
                else
                    state_next = ST_LAUNCH;
            end
            ST_LAUNCH:
                state_next = ST_RUN;
            ST_RUN:
            begin
                if (chain_out.valid)
                    state_next = ST_FINAL;
            end
            ST_FINAL:
            begin
                if (steer_raw > 19'sd32767)
                    res_next.steer_angle = 16'sh7FFF;
                else if (steer_raw < -19'sd32768)
                    res_next.steer_angle = 16'sh8000;
                else
                    res_next.steer_angle = steer_raw[15:0];
                res_next.throttle_on = 1'b1;
                res_next.advanced    = adv_reg;
                res_next.all_done    = 1'b0;
                res_next.status_code = wsg_pkg::STATUS_OK;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            count_reg     <= '0;
            adv_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            tol_reg       <= wsg_pkg::TOL_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            count_reg     <= count_next;
            adv_reg       <= adv_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                tol_reg <= cfg_wr_data;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
            item_reg <= in_data;
        if (state_reg == ST_DIFF)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (state_reg == ST_MUL)
        begin
            sqx_reg  <= prod_x[47:0];
            sqy_reg  <= prod_y[47:0];
            tol2_reg <= tol_reg * tol_reg;
        end
        if (state_reg == ST_RUN)
            bearing_reg <= bearing_next;
        res_reg <= res_next;
        if ((state_reg == ST_EMIT) && out_free)
            out_data_reg <= res_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// Waypoint steering guidance testbench
// Drives load and status beats into the guidance block, predicts each result
// beat from a local model of the waypoint queue, the reach check and the
// CORDIC bearing, and checks every result beat field by field. A short
// directed section is followed by random routes under several reach radii.
// ----------------------------------------------------------------------------
module testbench;

    localparam int     DEPTH        = 16;
    localparam int     ITERS        = 16;
    localparam longint ANG_PI       = 12868;
    localparam longint ANG_2PI      = 25736;
    localparam longint ANG_PI_Q24   = 52707179;
    localparam longint ROUND_HALF   = 2048;
    localparam int     N_PHASES     = 6;
    localparam int     PHASE_ITEMS  = 305;
    localparam int     HOLD_AT      = 150;
    localparam int     HOLD_CYCLES  = 400;
    localparam int     DRAIN_CYCLES = 40;
    localparam int     CYCLE_LIMIT  = 600000;

    // atan(2^-i) in Q.24 radians
    localparam longint ATAN_Q24 [0:ITERS-1] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512
    };

    // Per-phase settings: reach radius and idle probabilities in percent
    localparam int PHASE_TOL [0:N_PHASES-1] = '{0, 65535, 819, -1, 1, -1};
    localparam int DRV_PCT   [0:N_PHASES-1] = '{20, 0, 35, 10, 25, 0};
    localparam int MON_PCT   [0:N_PHASES-1] = '{20, 30, 0, 10, 25, 0};

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic               in_stall;
    wsg_pkg::in_beat_t  in_data     = '0;
    logic               out_valid;
    logic               out_stall   = 1'b0;
    wsg_pkg::out_beat_t out_data;
    logic               cfg_wr_en   = 1'b0;
    logic [15:0]        cfg_wr_data = '0;

    // Local copy of the guidance state
    logic signed [23:0] wp_x_mem [DEPTH];
    logic signed [23:0] wp_y_mem [DEPTH];
    int unsigned        head_idx;
    int unsigned        wp_count;
    logic [15:0]        reach_tol;

    // Stimulus and result bookkeeping
    wsg_pkg::in_beat_t  stim_q [$];
    wsg_pkg::out_beat_t expected_cmds [$];
    logic [23:0]  route_x [$];
    logic [23:0]  route_y [$];
    int           route_tol;
    int           drv_idle_pct;
    int           mon_idle_pct;
    int           drv_idle;
    int           mon_idle;
    int           hold_left;
    bit           hold_done;
    int           results_seen;
    int           n_fail;
    int           cycles;
    wsg_pkg::out_beat_t want_beat;

    waypoint_steering_guidance_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 clk = ~clk;

    // Bearing atan2(dx, dy) in [0, 2pi), Q3.12, by vectoring CORDIC
    function automatic longint bearing_q12(longint dx, longint dy);
        longint x;
        longint y;
        longint z;
        longint t;
        int     i;
        if (dx == 0)
            return (dy >= 0) ? 0 : ANG_PI;
        if (dy < 0)
        begin
            x = -dy;
            y = -dx;
            z = ANG_PI_Q24;
        end
        else
        begin
            x = dy;
            y = dx;
            z = 0;
        end
        for (i = 0; i < ITERS; i++)
        begin
            t = x;
            if (y >= 0)
            begin
                x = x + (y >>> i);
                y = y - (t >>> i);
                z = z + ATAN_Q24[i];
            end
            else
            begin
                x = x - (y >>> i);
                y = y + (t >>> i);
                z = z - ATAN_Q24[i];
            end
        end
        z = (z + ROUND_HALF) >>> 12;
        if (dy >= 0 && dx < 0)
            z = z + ANG_2PI;
        return z;
    endfunction

    // Result beat for one accepted input beat; updates the local queue state
    function automatic wsg_pkg::out_beat_t predict_guidance(wsg_pkg::in_beat_t b);
        wsg_pkg::out_beat_t r;
        longint      px;
        longint      py;
        longint      hd;
        longint      dx;
        longint      dy;
        longint      d2;
        longint      tol2;
        longint      tgt;
        longint      steer;
        int unsigned slot;
        r  = '0;
        px = longint'($signed(b.pos_x));
        py = longint'($signed(b.pos_y));
        hd = longint'($signed(b.heading));
        r.status_code = wsg_pkg::STATUS_OK;
        if (b.opcode == wsg_pkg::OP_LOAD)
        begin
            if (wp_count >= DEPTH)
                r.status_code = wsg_pkg::STATUS_FULL;
            else
            begin
                slot = (head_idx + wp_count) % DEPTH;
                wp_x_mem[slot] = b.pos_x;
                wp_y_mem[slot] = b.pos_y;
                wp_count++;
            end
            return r;
        end
        if (wp_count == 0)
        begin
            r.all_done    = 1'b1;
            r.status_code = wsg_pkg::STATUS_EMPTY;
            return r;
        end
        dx   = longint'(wp_x_mem[head_idx]) - px;
        dy   = longint'(wp_y_mem[head_idx]) - py;
        d2   = dx * dx + dy * dy;
        tol2 = longint'(reach_tol) * longint'(reach_tol);
        // Drop the head waypoint when reached; the next one is not rechecked
        if (d2 <= tol2)
        begin
            head_idx   = (head_idx + 1) % DEPTH;
            wp_count--;
            r.advanced = 1'b1;
            if (wp_count == 0)
            begin
                r.all_done = 1'b1;
                return r;
            end
            dx = longint'(wp_x_mem[head_idx]) - px;
            dy = longint'(wp_y_mem[head_idx]) - py;
        end
        tgt   = bearing_q12(dx, dy);
        steer = tgt - hd;
        if (hd > tgt + ANG_PI)
            steer = steer + ANG_2PI;
        else if (hd < tgt - ANG_PI)
            steer = steer - ANG_2PI;
        if (steer > 32767)
            steer = 32767;
        if (steer < -32768)
            steer = -32768;
        r.steer_angle = 16'(steer);
        r.throttle_on = 1'b1;
        return r;
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            n_fail++;
        end
    endfunction

    // Input driver: holds a stalled beat, otherwise idles or sends the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            drv_idle = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_cmds.push_back(predict_guidance(in_data));
            if (in_valid && in_stall)
                in_valid <= 1'b1;
            else if (drv_idle > 0)
            begin
                drv_idle--;
                in_valid <= 1'b0;
            end
            else if (stim_q.size() > 0 && drv_idle_pct > 0 &&
                     $urandom_range(0, 99) < drv_idle_pct)
            begin
                drv_idle = $urandom_range(1, 10) - 1;
                in_valid <= 1'b0;
            end
            else if (stim_q.size() > 0)
            begin
                in_valid <= 1'b1;
                in_data  <= stim_q.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result monitor and output stall generator
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            mon_idle  = 0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_cmds.size() == 0)
                begin
                    $error("result beat with no expected command pending");
                    n_fail++;
                end
                else
                begin
                    want_beat = expected_cmds.pop_front();
                    check_field("steer_angle", $signed(want_beat.steer_angle),
                                $signed(out_data.steer_angle));
                    check_field("throttle_on", want_beat.throttle_on,
                                out_data.throttle_on);
                    check_field("advanced", want_beat.advanced, out_data.advanced);
                    check_field("all_done", want_beat.all_done, out_data.all_done);
                    check_field("status_code", want_beat.status_code,
                                out_data.status_code);
                end
            end
            // One long hold so the block backs up into its input
            if (!hold_done && results_seen >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (mon_idle > 0)
            begin
                mon_idle--;
                out_stall <= 1'b1;
            end
            else if (mon_idle_pct > 0 && $urandom_range(0, 99) < mon_idle_pct)
            begin
                mon_idle = $urandom_range(1, 10) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic stim_push(logic op, logic [23:0] x, logic [23:0] y, logic [15:0] h);
        wsg_pkg::in_beat_t b;
        b.opcode  = op;
        b.pos_x   = x;
        b.pos_y   = y;
        b.heading = h;
        stim_q.push_back(b);
    endtask

    function automatic logic [15:0] rand_heading();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return ($urandom_range(0, 1) != 0) ? 24'h800000 : 24'h7FFFFF;
            1, 2, 3: return 24'(int'($urandom_range(0, 131072)) - 65536);
            default: return 24'($urandom);
        endcase
    endfunction

    // Rover coordinate at offset off from the waypoint, mirrored if out of range
    function automatic logic [23:0] place(logic [23:0] wp, longint off);
        longint p;
        p = longint'($signed(wp)) - off;
        if (p < -8388608 || p > 8388607)
            p = longint'($signed(wp)) + off;
        return 24'(p);
    endfunction

    function automatic longint rand_offset(int m);
        return longint'($urandom_range(0, 2 * m)) - m;
    endfunction

    task automatic gen_load(logic [23:0] x, logic [23:0] y);
        stim_push(wsg_pkg::OP_LOAD, x, y, 16'($urandom));
        if (route_x.size() < DEPTH)
        begin
            route_x.push_back(x);
            route_y.push_back(y);
        end
    endtask

    // Status beat inside the reach radius of the head waypoint
    task automatic gen_near();
        int m;
        m = route_tol / 2;
        if (route_x.size() == 0)
            stim_push(wsg_pkg::OP_STEP, 24'($urandom), 24'($urandom), rand_heading());
        else
        begin
            stim_push(wsg_pkg::OP_STEP, place(route_x[0], rand_offset(m)),
                      place(route_y[0], rand_offset(m)), rand_heading());
            void'(route_x.pop_front());
            void'(route_y.pop_front());
        end
    endtask

    // Status beat clearly outside the reach radius
    task automatic gen_far();
        longint big;
        longint other;
        if (route_x.size() == 0 || $urandom_range(0, 3) == 0)
            stim_push(wsg_pkg::OP_STEP, 24'($urandom), 24'($urandom), rand_heading());
        else
        begin
            big = longint'(route_tol) + 1 + $urandom_range(0, 200000);
            if ($urandom_range(0, 1) != 0)
                big = -big;
            other = ($urandom_range(0, 5) == 0) ? 0 : rand_offset(200000);
            if ($urandom_range(0, 1) != 0)
                stim_push(wsg_pkg::OP_STEP, place(route_x[0], big),
                          place(route_y[0], other), rand_heading());
            else
                stim_push(wsg_pkg::OP_STEP, place(route_x[0], other),
                          place(route_y[0], big), rand_heading());
        end
    endtask

    // One route: load waypoints, then approach each one in turn
    task automatic gen_route();
        int n;
        int i;
        int k;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 19) : $urandom_range(1, 6);
        for (i = 0; i < n; i++)
            gen_load(rand_coord(), rand_coord());
        while (route_x.size() > 0)
        begin
            k = $urandom_range(0, 3);
            repeat (k) gen_far();
            if ($urandom_range(0, 7) == 0)
                gen_load(rand_coord(), rand_coord());
            if ($urandom_range(0, 11) == 0)
            begin
                if ($urandom_range(0, 1) != 0)
                    gen_load(24'($urandom), 24'($urandom));
                else
                    stim_push(wsg_pkg::OP_STEP, 24'($urandom), 24'($urandom),
                              16'($urandom));
            end
            gen_near();
        end
        if ($urandom_range(0, 3) == 0)
            gen_near();
    endtask

    // Wait until nothing is pending or in flight, then let the block settle
    task automatic settle();
        do
            @(negedge clk);
        while (!(stim_q.size() == 0 && !in_valid && expected_cmds.size() == 0));
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_tol(logic [15:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        reach_tol = v;
        route_tol = v;
        @(negedge clk);
    endtask

    initial
    begin
        int p;
        int tol;
        int target;
        head_idx     = 0;
        wp_count     = 0;
        reach_tol    = wsg_pkg::TOL_RESET;
        route_tol    = wsg_pkg::TOL_RESET;
        drv_idle_pct = 15;
        mon_idle_pct = 15;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty queue, axis bearings, 2pi fix, heading wrap, exact reach
        stim_push(wsg_pkg::OP_STEP, 24'd0, 24'd0, 16'h1234);
        gen_load(24'd0, 24'd0);
        stim_push(wsg_pkg::OP_STEP, 24'd0, -24'sd4096, 16'h0000);
        stim_push(wsg_pkg::OP_STEP, 24'd0, 24'd4096, 16'h7FFF);
        stim_push(wsg_pkg::OP_STEP, 24'd4096, 24'd0, 16'h8000);
        stim_push(wsg_pkg::OP_STEP, 24'd819, 24'd0, 16'h0000);
        void'(route_x.pop_front());
        void'(route_y.pop_front());
        // Corner waypoints, fill the queue, one load into a full queue
        gen_load(24'h800000, 24'h800000);
        gen_load(24'h7FFFFF, 24'h7FFFFF);
        repeat (15) gen_load(rand_coord(), rand_coord());
        // Longest vector, then advance with bearing taken to the next waypoint
        stim_push(wsg_pkg::OP_STEP, 24'h7FFFFF, 24'h7FFFFF, 16'h0000);
        stim_push(wsg_pkg::OP_STEP, 24'h800000, 24'h800000, 16'h8000);
        void'(route_x.pop_front());
        void'(route_y.pop_front());
        settle();

        // Random routes under several reach radii
        for (p = 0; p < N_PHASES; p++)
        begin
            tol = (PHASE_TOL[p] < 0) ? $urandom_range(0, 65535) : PHASE_TOL[p];
            write_tol(16'(tol));
            drv_idle_pct = DRV_PCT[p];
            mon_idle_pct = MON_PCT[p];
            target = stim_q.size() + PHASE_ITEMS;
            while (stim_q.size() < target)
                gen_route();
            settle();
        end

        if (n_fail == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// File: waypoint_steering_guidance_top.f
rtl/core/wsg_pkg.sv
rtl/core/wsg_cordic_cell.sv
rtl/core/wsg_cordic_chain.sv
rtl/core/waypoint_steering_guidance_top.sv
dv/testbench.sv
